// ----- design/bped_pkg.sv -----
// -----------------------------------------------------------------------------
// bped_pkg: shared types and constants for the button press event detector
// Field widths, event codes, register indexes, reset values and the
// structs passed between the detector modules.
// -----------------------------------------------------------------------------
package bped_pkg;

  // field widths
  localparam int unsigned CntW   = 16;
  localparam int unsigned ClickW = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DataW  = 16;

  // saturation limits
  localparam logic [CntW-1:0]   CNT_MAX   = 16'hFFFF;
  localparam logic [ClickW-1:0] CLICK_MAX = 8'hFF;

  // event codes
  localparam logic [KindW-1:0] EV_PRESS         = 3'd0;
  localparam logic [KindW-1:0] EV_MULTI_PRESS   = 3'd1;
  localparam logic [KindW-1:0] EV_RELEASE       = 3'd2;
  localparam logic [KindW-1:0] EV_LONG_PRESS    = 3'd3;
  localparam logic [KindW-1:0] EV_LONG_RELEASE  = 3'd4;
  localparam logic [KindW-1:0] EV_MULTI_RELEASE = 3'd5;

  // register indexes
  localparam logic [IdxW-1:0] REG_HOLD_LIMIT     = 3'd0;
  localparam logic [IdxW-1:0] REG_DEBOUNCE_LIMIT = 3'd1;
  localparam logic [IdxW-1:0] REG_MULTI_INTERVAL = 3'd2;
  localparam logic [IdxW-1:0] REG_ACTIVE_LEVEL   = 3'd3;
  localparam logic [IdxW-1:0] REG_KEY_ENABLE     = 3'd4;

  // register reset values
  localparam logic [CntW-1:0] HOLD_LIMIT_RST     = 16'd25;
  localparam logic [CntW-1:0] DEBOUNCE_LIMIT_RST = 16'd1;
  localparam logic [CntW-1:0] MULTI_INTERVAL_RST = 16'd15;
  localparam logic            ACTIVE_LEVEL_RST   = 1'b0;
  localparam logic            KEY_ENABLE_RST     = 1'b1;

  // configuration seen by the detector
  typedef struct packed {
    logic [CntW-1:0] hold_limit;
    logic [CntW-1:0] debounce_limit;
    logic [CntW-1:0] multi_interval;
    logic            active_level;
    logic            key_enable;
  } bped_cfg_t;

  // event produced by one tick
  typedef struct packed {
    logic              fire;
    logic [KindW-1:0]  kind;
    logic [ClickW-1:0] count;
  } bped_evt_t;

endpackage

// ----- design/bped_if.sv -----
// -----------------------------------------------------------------------------
// bped_if: valid/ready channels of the button press event detector
// Key sample channel and event result channel.
// -----------------------------------------------------------------------------
interface bped_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink   (input valid, input key_level, output ready);
endinterface

interface bped_evt_if;
  logic                          valid;
  logic                          ready;
  logic [bped_pkg::KindW-1:0]    event_kind;
  logic [bped_pkg::ClickW-1:0]   press_count;

  modport source (output valid, output event_kind, output press_count, input ready);
  modport sink   (input valid, input event_kind, input press_count, output ready);
endinterface

// ----- design/bped_cfg.sv -----
// -----------------------------------------------------------------------------
// bped_cfg: configuration registers
// Write-only register file; writes to an unknown index are dropped.
// -----------------------------------------------------------------------------
module bped_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bped_pkg::IdxW-1:0]  cfg_index,
  input  logic [bped_pkg::DataW-1:0] cfg_data,
  output bped_pkg::bped_cfg_t        cfg
);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_limit     <= bped_pkg::HOLD_LIMIT_RST;
      cfg.debounce_limit <= bped_pkg::DEBOUNCE_LIMIT_RST;
      cfg.multi_interval <= bped_pkg::MULTI_INTERVAL_RST;
      cfg.active_level   <= bped_pkg::ACTIVE_LEVEL_RST;
      cfg.key_enable     <= bped_pkg::KEY_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bped_pkg::REG_HOLD_LIMIT:     cfg.hold_limit     <= cfg_data;
        bped_pkg::REG_DEBOUNCE_LIMIT: cfg.debounce_limit <= cfg_data;
        bped_pkg::REG_MULTI_INTERVAL: cfg.multi_interval <= cfg_data;
        bped_pkg::REG_ACTIVE_LEVEL:   cfg.active_level   <= cfg_data[0];
        bped_pkg::REG_KEY_ENABLE:     cfg.key_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/bped_fsm.sv -----
// -----------------------------------------------------------------------------
// bped_fsm: key state machine
// Holds the pressed state and counters and works out one tick per step:
// window aging, debounce, long press and release events.
// -----------------------------------------------------------------------------
module bped_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                key_level,
  input  bped_pkg::bped_cfg_t cfg,
  output bped_pkg::bped_evt_t evt
);

  localparam logic ST_UNPRESSED = 1'b0;
  localparam logic ST_PRESSED   = 1'b1;

  logic                        state;
  logic [bped_pkg::CntW-1:0]   hold_count;
  logic [bped_pkg::CntW-1:0]   window_count;
  logic [bped_pkg::ClickW-1:0] click_count;
  logic                        long_seen;

  logic                        state_next;
  logic [bped_pkg::CntW-1:0]   hold_count_next;
  logic [bped_pkg::CntW-1:0]   window_count_next;
  logic [bped_pkg::ClickW-1:0] click_count_next;
  logic                        long_seen_next;

  logic                        active;
  logic [bped_pkg::CntW-1:0]   window_aged;
  logic [bped_pkg::CntW-1:0]   hold_inc;
  logic [bped_pkg::ClickW-1:0] click_aged;

  assign active = (key_level == cfg.active_level);
  assign hold_inc = (hold_count == bped_pkg::CNT_MAX) ? hold_count
                                                      : hold_count + 16'd1;

  // multi-press window aging
  always_comb begin
    window_aged = window_count;
    click_aged  = click_count;
    if (click_count != '0) begin
      window_aged = (window_count == bped_pkg::CNT_MAX) ? window_count
                                                        : window_count + 16'd1;
      if (window_aged > cfg.multi_interval) begin
        window_aged = '0;
        click_aged  = '0;
      end
    end
  end

  // tick update and event selection
  always_comb begin
    state_next        = state;
    hold_count_next   = hold_count;
    window_count_next = window_aged;
    click_count_next  = click_aged;
    long_seen_next    = long_seen;
    evt.fire          = 1'b0;
    evt.kind          = bped_pkg::EV_PRESS;
    unique case (state)
      ST_UNPRESSED: begin
        if (active) begin
          hold_count_next = hold_inc;
          if (hold_count >= cfg.debounce_limit) begin
            state_next        = ST_PRESSED;
            hold_count_next   = 16'd1;
            window_count_next = '0;
            if (click_aged != bped_pkg::CLICK_MAX) begin
              click_count_next = click_aged + 8'd1;
            end
            evt.fire = 1'b1;
            evt.kind = (click_count_next > 8'd1) ? bped_pkg::EV_MULTI_PRESS
                                                 : bped_pkg::EV_PRESS;
          end
        end
      end
      ST_PRESSED: begin
        hold_count_next = hold_inc;
        if (!active) begin
          state_next      = ST_UNPRESSED;
          hold_count_next = '0;
          evt.fire        = 1'b1;
          if (click_aged > 8'd1) begin
            evt.kind = bped_pkg::EV_MULTI_RELEASE;
          end else if (long_seen) begin
            long_seen_next = 1'b0;
            evt.kind       = bped_pkg::EV_LONG_RELEASE;
          end else begin
            evt.kind = bped_pkg::EV_RELEASE;
          end
        end else if (hold_inc == cfg.hold_limit) begin
          long_seen_next = 1'b1;
          evt.fire       = 1'b1;
          evt.kind       = bped_pkg::EV_LONG_PRESS;
        end
      end
      default: ;
    endcase
    // a disabled key sees nothing
    if (!cfg.key_enable) begin
      evt.fire = 1'b0;
    end
    evt.count = click_count_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_UNPRESSED;
      hold_count   <= '0;
      window_count <= '0;
      click_count  <= '0;
      long_seen    <= 1'b0;
    end else if (step && cfg.key_enable) begin
      state        <= state_next;
      hold_count   <= hold_count_next;
      window_count <= window_count_next;
      click_count  <= click_count_next;
      long_seen    <= long_seen_next;
    end
  end

endmodule

// ----- design/button_press_event_detector.sv -----
// -----------------------------------------------------------------------------
// button_press_event_detector: debounce, multi-click and long press detector
// Turns a stream of sampled key levels into press and release events.
//
//   channel  dir  payload                        transfer when
//   key      in   key_level[0]                   key.valid && key.ready
//   evt      out  event_kind[2:0], press_count   evt.valid && evt.ready
//   cfg      in   cfg_index[2:0], cfg_data[15:0] cfg_we
//
// One key sample per cycle while the result register drains; a transferred sample
// goes to the input register, then the state update loads any event into the result register.
// Reset is synchronous: counters, state and registers return to defaults.
// A waiting result does not stop intake: the input register holds one more
// sample, and key.ready drops only while both stages are full and stalled.
// -----------------------------------------------------------------------------
module button_press_event_detector (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bped_pkg::IdxW-1:0]  cfg_index,
  input  logic [bped_pkg::DataW-1:0] cfg_data,
  bped_key_if.sink                   key,
  bped_evt_if.source                 evt
);

  bped_pkg::bped_cfg_t cfg;
  bped_pkg::bped_evt_t tick_evt;

  logic                          stg_valid;
  logic                          stg_level;
  logic                          advance;
  logic                          res_valid;
  logic [bped_pkg::KindW-1:0]    res_kind;
  logic [bped_pkg::ClickW-1:0]   res_count;

  bped_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bped_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .key_level (stg_level),
    .cfg       (cfg),
    .evt       (tick_evt)
  );

  // the staged sample moves on when the result register can take it
  assign advance   = stg_valid && (!res_valid || evt.ready);
  assign key.ready = !stg_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (key.valid && key.ready) begin
      stg_valid <= 1'b1;
    end else if (advance) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key.valid && key.ready) begin
      stg_level <= key.key_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && tick_evt.fire) begin
      res_valid <= 1'b1;
    end else if (evt.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tick_evt.fire) begin
      res_kind  <= tick_evt.kind;
      res_count <= tick_evt.count;
    end
  end

  assign evt.valid       = res_valid;
  assign evt.event_kind  = res_kind;
  assign evt.press_count = res_count;

  // checks
  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !key.ready |-> (stg_valid && res_valid && !evt.ready))
    else $error("key ready low without a stalled result");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(evt.valid) |-> $past(stg_valid))
    else $error("result appeared without a staged sample");

  a_multi_count: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && (evt.event_kind == bped_pkg::EV_MULTI_PRESS ||
                   evt.event_kind == bped_pkg::EV_MULTI_RELEASE))
    |-> (evt.press_count > 8'd1))
    else $error("multi event with press count below two");

  a_press_count: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.event_kind == bped_pkg::EV_PRESS) |-> (evt.press_count == 8'd1))
    else $error("single press with press count other than one");

endmodule
